### hw/rtl/swpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word deframer package
// Shared types, register indexes and CRC constants of the deframer.
// ----------------------------------------------------------------------------
package swpd_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  localparam logic [31:0] SyncWordReset  = 32'hFFFD_FEFF;
  localparam logic [15:0] MaxLengthReset = 16'hFFFF;

  localparam int unsigned CfgIndexBits = 2;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgCheckEnable = 2'd0,
    CfgSyncWord    = 2'd1,
    CfgMaxLength   = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusCrcErr = 2'd1,
    StatusLenErr = 2'd2
  } frame_status_e;

  typedef struct packed {
    logic [1:0] frame_status;
    logic       frame_end;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } result_t;

endpackage

### hw/rtl/swpd_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 byte update
// Advances a reflected CRC-32 register by one data byte, LSB first.
// ----------------------------------------------------------------------------
module swpd_crc_byte (
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ swpd_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

### hw/rtl/sync_word_packet_deframer_crc32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word packet deframer with CRC-32 check
// Finds a sync word in a byte stream, parses length and optional CRC, and
// forwards the payload bytes with an end marker and a frame status.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one received byte per word. The block hunts for the
//   four sync bytes (partial overlaps are followed), then reads a big-endian
//   32-bit length and, with check_enable set, a big-endian 32-bit CRC-32.
//   Each payload byte leaves on the master stream with tuser[0] set; the last
//   one carries tlast and the frame status in tuser[2:1]. Empty frames and
//   over-limit lengths give a single word with tlast and tuser[0] clear.
//   Each accepted byte's result word is registered, and one byte is taken
//   every cycle while the skid register is empty: the CRC byte update and
//   the parser state sit between the input handshake and the output register.
//   A two-entry output stage (output register plus skid register) lets the
//   input keep flowing for one more word while the receiver stalls; tready
//   drops only when both entries hold words.
//   Reset clears the parser to hunting and loads the register defaults.
//   The configuration channel is always ready; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_crc32 #(
  parameter int unsigned LEN_LIMIT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields: in_byte [7:0].
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields: payload_byte [7:0].
  output logic [7:0]  m_axis_tdata_o,
  // Fields: payload_valid [0], frame_status [2:1].
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [swpd_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PhHunt,
    PhLen,
    PhCrc,
    PhData
  } phase_e;

  // Configuration registers.
  logic        check_en_q;
  logic [31:0] sync_word_q;
  logic [15:0] max_len_q;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [1:0]  matched_q, matched_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic [31:0] crc_q, crc_d;

  // Output stage.
  swpd_pkg::result_t out_q, skid_q, res;
  logic              out_valid_q, skid_valid_q, res_valid;

  logic                      in_fire;
  logic [LEN_LIMIT_BITS-1:0] limit;
  logic [31:0]               len_next, rx_crc_next, crc_next;
  logic [2:0]                sync_next;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.payload_byte;
  assign m_axis_tuser_o  = {out_q.frame_status, out_q.payload_valid};
  assign m_axis_tlast_o  = out_q.frame_end;

  if (LEN_LIMIT_BITS >= 16) begin : g_limit_wide
    assign limit = LEN_LIMIT_BITS'(max_len_q);
  end else begin : g_limit_narrow
    assign limit = max_len_q[LEN_LIMIT_BITS-1:0];
  end

  assign len_next    = {len_q[23:0], s_axis_tdata_i};
  assign rx_crc_next = {rx_crc_q[23:0], s_axis_tdata_i};

  swpd_crc_byte u_crc (
    .crc_i  (crc_q),
    .data_i (s_axis_tdata_i),
    .crc_o  (crc_next)
  );

  // Longest prefix of the sync word that ends the matched prefix followed by
  // the new byte. Larger candidates are tried last so they win.
  function automatic logic [2:0] sync_advance(input logic [1:0]  m,
                                              input logic [7:0]  b,
                                              input logic [31:0] w);
    logic [7:0] sb [4];
    logic [2:0] res_k;
    logic       ok;
    int         idx;
    for (int i = 0; i < 4; i++) begin
      sb[i] = w[8*(3-i) +: 8];
    end
    res_k = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (k <= int'(m) + 1) begin
        ok = (sb[2'(k-1)] == b);
        for (int j = 0; j < k - 1; j++) begin
          idx = int'(m) + 1 - k + j;
          if (sb[2'(idx)] != sb[2'(j)]) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          res_k = 3'(k);
        end
      end
    end
    return res_k;
  endfunction

  assign sync_next = sync_advance(matched_q, s_axis_tdata_i, sync_word_q);

  always_comb begin
    logic [31:0] len_dec;
    phase_d    = phase_q;
    matched_d  = matched_q;
    byte_idx_d = byte_idx_q;
    len_d      = len_q;
    rx_crc_d   = rx_crc_q;
    crc_d      = crc_q;
    res        = '0;
    res_valid  = 1'b0;
    len_dec    = (len_q == 32'd0) ? 32'd0 : len_q - 32'd1;

    case (phase_q)
      PhHunt: begin
        if (sync_next[2]) begin
          phase_d    = PhLen;
          matched_d  = 2'd0;
          byte_idx_d = 2'd0;
          len_d      = 32'd0;
          rx_crc_d   = 32'd0;
          crc_d      = swpd_pkg::CrcOnes;
        end else begin
          matched_d = sync_next[1:0];
        end
      end
      PhLen: begin
        len_d = len_next;
        if (byte_idx_q != 2'd3) begin
          byte_idx_d = byte_idx_q + 2'd1;
        end else begin
          byte_idx_d = 2'd0;
          if (len_next > 32'(limit)) begin
            phase_d            = PhHunt;
            matched_d          = 2'd0;
            res_valid          = 1'b1;
            res.frame_end      = 1'b1;
            res.frame_status   = swpd_pkg::StatusLenErr;
          end else if (check_en_q) begin
            phase_d = PhCrc;
          end else if (len_next == 32'd0) begin
            phase_d          = PhHunt;
            matched_d        = 2'd0;
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.frame_status = swpd_pkg::StatusOk;
          end else begin
            phase_d = PhData;
          end
        end
      end
      PhCrc: begin
        rx_crc_d = rx_crc_next;
        if (byte_idx_q != 2'd3) begin
          byte_idx_d = byte_idx_q + 2'd1;
        end else begin
          byte_idx_d = 2'd0;
          if (len_q == 32'd0) begin
            phase_d       = PhHunt;
            matched_d     = 2'd0;
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
            res.frame_status = ((crc_q ^ swpd_pkg::CrcOnes) == rx_crc_next) ?
                               swpd_pkg::StatusOk : swpd_pkg::StatusCrcErr;
          end else begin
            phase_d = PhData;
          end
        end
      end
      PhData: begin
        crc_d             = crc_next;
        len_d             = len_dec;
        res_valid         = 1'b1;
        res.payload_byte  = s_axis_tdata_i;
        res.payload_valid = 1'b1;
        if (len_dec == 32'd0) begin
          phase_d       = PhHunt;
          matched_d     = 2'd0;
          byte_idx_d    = 2'd0;
          res.frame_end = 1'b1;
          if (check_en_q && ((crc_next ^ swpd_pkg::CrcOnes) != rx_crc_q)) begin
            res.frame_status = swpd_pkg::StatusCrcErr;
          end else begin
            res.frame_status = swpd_pkg::StatusOk;
          end
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q   <= 1'b0;
      sync_word_q  <= swpd_pkg::SyncWordReset;
      max_len_q    <= swpd_pkg::MaxLengthReset;
      phase_q      <= PhHunt;
      matched_q    <= 2'd0;
      byte_idx_q   <= 2'd0;
      len_q        <= 32'd0;
      rx_crc_q     <= 32'd0;
      crc_q        <= swpd_pkg::CrcOnes;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          swpd_pkg::CfgCheckEnable: check_en_q  <= cfg_data_i[0];
          swpd_pkg::CfgSyncWord:    sync_word_q <= cfg_data_i;
          swpd_pkg::CfgMaxLength:   max_len_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        phase_q    <= phase_d;
        matched_q  <= matched_d;
        byte_idx_q <= byte_idx_d;
        len_q      <= len_d;
        rx_crc_q   <= rx_crc_d;
        crc_q      <= crc_d;
      end

      // While the skid entry is full no new word is accepted.
      if (skid_valid_q) begin
        if (m_axis_tready_i) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (!out_valid_q || m_axis_tready_i) begin
        out_valid_q <= in_fire && res_valid;
        out_q       <= res;
      end else if (in_fire && res_valid) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/swpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the output stream of the deframer for illegal result words.
// ----------------------------------------------------------------------------
module swpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i
);

  // A stalled word must be held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // Status codes beyond the length error are never produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o[2:1] != 2'd3)
    else $error("reserved frame status");

  // A word without payload is always a frame end with zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tlast_o && m_axis_tdata_o == 8'd0)
    else $error("empty word is not a zero frame end");

  // Status is only reported on the word that closes a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      m_axis_tuser_o[2:1] == swpd_pkg::StatusOk)
    else $error("status outside a frame end");

  // A length error never comes with a payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2:1] == swpd_pkg::StatusLenErr |->
      !m_axis_tuser_o[0])
    else $error("length error on a payload word");

endmodule

bind sync_word_packet_deframer_crc32 swpd_checker u_swpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

### tb/sv/swpd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench scoreboard
// Tracks the parser state of the sync word deframer for every accepted input
// word, queues the output words it must produce and checks the observed ones.
// ----------------------------------------------------------------------------
package swpd_tb_pkg;

  import swpd_pkg::*;

  localparam int unsigned LenLimitBits = 16;

  // Index 3 maps to no register; writes there must be dropped.
  localparam logic [1:0] CfgSpareIndex = 2'd3;

  typedef enum logic [1:0] {
    ParseHunt,
    ParseLength,
    ParseCrc,
    ParsePayload
  } parse_state_e;

  // One byte of the reflected CRC-32, shared by the predictor and the frame builder.
  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  class deframer_scoreboard;

    bit           check_en;
    logic [31:0]  sync_word;
    logic [15:0]  max_len;

    parse_state_e state;
    int unsigned  matched;
    int unsigned  field_idx;
    logic [31:0]  len_left;
    logic [31:0]  rx_crc;
    logic [31:0]  run_crc;

    result_t      frame_words_q[$];
    int unsigned  errors;
    int unsigned  words_seen;

    function new();
      check_en   = 1'b0;
      sync_word  = SyncWordReset;
      max_len    = MaxLengthReset;
      state      = ParseHunt;
      matched    = 0;
      field_idx  = 0;
      len_left   = '0;
      rx_crc     = '0;
      run_crc    = CrcOnes;
      errors     = 0;
      words_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CfgCheckEnable: check_en = data[0];
        CfgSyncWord:    sync_word = data;
        CfgMaxLength:   max_len = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] limit();
      logic [31:0] m;
      m = {16'd0, max_len};
      if (LenLimitBits < 32) m &= (32'd1 << LenLimitBits) - 32'd1;
      return m;
    endfunction

    function logic [7:0] sync_at(int i);
      return sync_word[8*(3-i) +: 8];
    endfunction

    // Longest sync prefix that ends the matched prefix followed by b, so that
    // partial overlaps are not lost.
    function int unsigned sync_next(int unsigned m, logic [7:0] b);
      int  k;
      int  j;
      int  mm;
      bit  ok;
      mm = (m > 3) ? 3 : int'(m);
      for (k = mm + 1; k >= 1; k--) begin
        ok = 1'b1;
        for (j = 0; j + 1 < k; j++) begin
          if (sync_at(mm + 1 - k + j) != sync_at(j)) ok = 1'b0;
        end
        if (ok && sync_at(k - 1) == b) return k;
      end
      return 0;
    endfunction

    function frame_status_e crc_verdict();
      return ((run_crc ^ CrcOnes) == rx_crc) ? StatusOk : StatusCrcErr;
    endfunction

    function void restart();
      state     = ParseHunt;
      matched   = 0;
      field_idx = 0;
    endfunction

    function void expect_word(logic [7:0] data, logic valid, logic closes,
                              frame_status_e st);
      result_t w;
      w.payload_byte  = data;
      w.payload_valid = valid;
      w.frame_end     = closes;
      w.frame_status  = st;
      frame_words_q.push_back(w);
    endfunction

    function bit in_frame();
      return state != ParseHunt;
    endfunction

    function int unsigned pending();
      return frame_words_q.size();
    endfunction

    // Notes one accepted input word and queues the output word it causes, if any.
    function void take_byte(logic [7:0] b);
      int unsigned   m;
      frame_status_e st;
      case (state)
        ParseHunt: begin
          m = sync_next(matched, b);
          if (m >= 4) begin
            state     = ParseLength;
            matched   = 0;
            field_idx = 0;
            len_left  = '0;
            rx_crc    = '0;
            run_crc   = CrcOnes;
          end else begin
            matched = m;
          end
        end
        ParseLength: begin
          len_left = {len_left[23:0], b};
          if (field_idx < 3) begin
            field_idx++;
          end else begin
            field_idx = 0;
            if (len_left > limit()) begin
              restart();
              expect_word(8'h00, 1'b0, 1'b1, StatusLenErr);
            end else if (check_en) begin
              state = ParseCrc;
            end else if (len_left == 0) begin
              restart();
              expect_word(8'h00, 1'b0, 1'b1, StatusOk);
            end else begin
              state = ParsePayload;
            end
          end
        end
        ParseCrc: begin
          rx_crc = {rx_crc[23:0], b};
          if (field_idx < 3) begin
            field_idx++;
          end else begin
            field_idx = 0;
            if (len_left == 0) begin
              st = crc_verdict();
              restart();
              expect_word(8'h00, 1'b0, 1'b1, st);
            end else begin
              state = ParsePayload;
            end
          end
        end
        default: begin
          run_crc = crc32_update(run_crc, b);
          if (len_left != 0) len_left--;
          if (len_left == 0) begin
            st = check_en ? crc_verdict() : StatusOk;
            restart();
            expect_word(b, 1'b1, 1'b1, st);
          end else begin
            expect_word(b, 1'b1, 1'b0, StatusOk);
          end
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at output word %0d: %s", words_seen, what);
    endtask

    task check_word(logic [7:0] data, logic [2:0] user, logic last);
      result_t want;
      words_seen++;
      if (frame_words_q.size() == 0) begin
        report($sformatf("unexpected word data %02h user %03b last %0b", data, user, last));
        return;
      end
      want = frame_words_q.pop_front();
      if (data !== want.payload_byte)
        report($sformatf("payload_byte %02h, expected %02h", data, want.payload_byte));
      if (user[0] !== want.payload_valid)
        report($sformatf("payload_valid %0b, expected %0b", user[0], want.payload_valid));
      if (user[2:1] !== want.frame_status)
        report($sformatf("frame_status %0d, expected %0d", user[2:1], want.frame_status));
      if (last !== want.frame_end)
        report($sformatf("frame_end %0b, expected %0b", last, want.frame_end));
    endtask

  endclass

endpackage

### tb/sv/sync_word_packet_deframer_crc32_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word packet deframer testbench
// Feeds byte streams with sync words, length and CRC fields, noise and broken
// sync sequences under several register settings, with random gaps and
// receiver stalls, and checks every output word against a scoreboard.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_crc32_tb;

  import swpd_pkg::*;
  import swpd_tb_pkg::*;

  localparam int unsigned TargetBytes = 550;
  localparam int unsigned CycleLimit  = 250000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  deframer_scoreboard sb = new();

  int unsigned sent_bytes = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  bit          snd_steady = 1'b0;
  bit          force_steady = 1'b0;

  sync_word_packet_deframer_crc32 #(
    .LEN_LIMIT_BITS(LenLimitBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any flop of the design moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.take_byte(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // Receiver: a random stall before each word, steady stretches now and then,
  // and one long hold-off when the stimulus asks for it.
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    bit          rcv_steady;
    taken = 0;
    rcv_steady = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) rcv_steady = ($urandom_range(0, 3) == 0);
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = rcv_steady ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  end

  // Valid stays high from one word to the next when no gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = snd_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= b;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_bytes++;
  endtask

  task automatic send_word32(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  // Waits until every queued output word has arrived, plus the pipeline depth.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Brings the parser back to hunting so that no register change lands mid-frame.
  task automatic settle();
    drain();
    while (sb.in_frame()) begin
      send_byte(8'h00);
      drain();
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // With a large limit, noise avoids the sync bytes so that no stray match can
  // open a frame tens of thousands of bytes long.
  function automatic logic [7:0] noise_byte(input bit safe);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (safe && (b == sb.sync_word[31:24] || b == sb.sync_word[23:16] ||
                        b == sb.sync_word[15:8] || b == sb.sync_word[7:0]));
    return b;
  endfunction

  task automatic send_frame(input logic [31:0] len, input bit crc_ok);
    logic [7:0]  body[$];
    logic [31:0] crc;
    crc = CrcOnes;
    send_word32(sb.sync_word);
    send_word32(len);
    if (len <= sb.limit()) begin
      for (int i = 0; i < len; i++) begin
        body.push_back(8'($urandom_range(0, 255)));
        crc = crc32_update(crc, body[i]);
      end
      crc ^= CrcOnes;
      if (sb.check_en) begin
        send_word32(crc_ok ? crc : crc ^ (32'd1 << $urandom_range(0, 31)));
      end
      foreach (body[i]) send_byte(body[i]);
    end
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned n;
    logic [31:0] lim;
    logic [31:0] len;
    lim = sb.limit();
    snd_steady = force_steady || ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 6)) send_byte(noise_byte(lim > 64));
    end else if (pick < 20) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_byte(sb.sync_at(i));
      send_byte(noise_byte(1'b1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      len = lim + 1;
    end else if (pick < 16) begin
      len = $urandom;
      if (len <= lim) len = lim + 1;
    end else begin
      if (pick < 26)      len = (lim > 64) ? $urandom_range(0, 8) : lim;
      else if (pick < 80) len = $urandom_range(0, 8);
      else                len = $urandom_range(9, 24);
      if (len > lim) len = lim;
    end
    send_frame(len, $urandom_range(0, 99) < 85);
  endtask

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned phase_end;
    bit          new_check;
    logic [31:0] new_sync;
    logic [15:0] new_max;
    logic [7:0]  pair[2];

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: an extra leading sync byte overlaps the real sync word,
    // then an empty frame.
    send_byte(8'hFF);
    send_word32(SyncWordReset);
    send_word32(32'd0);
    // A length one past the limit closes the frame with an error.
    send_word32(SyncWordReset);
    send_word32(32'h0001_0000);
    // Registers change while the length field is half read; they take effect
    // at its last byte.
    send_word32(SyncWordReset);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();
    write_reg(CfgMaxLength, 32'd2);
    write_reg(CfgCheckEnable, 32'd1);
    write_reg(CfgSpareIndex, $urandom);
    send_byte(8'h00);
    send_byte(8'h02);
    send_word32(crc32_update(crc32_update(CrcOnes, 8'h00), 8'hFF) ^ CrcOnes);
    send_byte(8'h00);
    send_byte(8'hFF);

    phase_no = 0;
    while (sent_bytes < TargetBytes) begin
      settle();
      case (phase_no)
        0: begin
          new_check = 1'b1;
          new_sync  = SyncWordReset;
          new_max   = 16'hFFFF;
        end
        1: begin
          new_check = 1'b0;
          new_sync  = 32'h0000_0000;
          new_max   = 16'h0000;
        end
        2: begin
          new_check = 1'b1;
          new_sync  = 32'hFFFF_FFFF;
          new_max   = 16'd12;
        end
        default: begin
          new_check = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 1) == 1) begin
            new_sync = $urandom;
          end else begin
            // Two byte values only, so that the sync word overlaps itself.
            pair[0] = 8'($urandom_range(0, 255));
            pair[1] = 8'($urandom_range(0, 255));
            for (int i = 0; i < 4; i++) new_sync[8*i +: 8] = pair[$urandom_range(0, 1)];
          end
          new_max = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
        end
      endcase
      write_reg(CfgCheckEnable, {31'd0, new_check});
      write_reg(CfgSyncWord, new_sync);
      write_reg(CfgMaxLength, {16'd0, new_max});
      if ($urandom_range(0, 3) == 0) write_reg(CfgSpareIndex, $urandom);

      // One phase keeps the input busy while the receiver holds off, so the
      // output stage fills and the input has to stall.
      force_steady = (phase_no == 3);
      if (phase_no == 3) hold_cycles = 300;

      phase_end = sent_bytes + 70;
      while (sent_bytes < phase_end && sent_bytes < TargetBytes) random_frame();
      phase_no++;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
